### design/nonmonotone_step_acceptance_macros.svh
// assertion macros for the nonmonotone step acceptance block
// depends on nothing; expects clk and rst in the scope of each use
`ifndef NONMONOTONE_STEP_ACCEPTANCE_MACROS_SVH
`define NONMONOTONE_STEP_ACCEPTANCE_MACROS_SVH

// same-cycle implication
`define NSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/nsa_pkg.sv
// shared types and constants for the nonmonotone step acceptance block
// used by nsa_divider and nonmonotone_step_acceptance; no dependencies
package nsa_pkg;

  localparam int MeritW = 64;
  localparam int RatioW = 32;
  localparam int ThreshW = 31;
  localparam int LimitW = 16;
  localparam int CfgDataW = 31;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] REG_ACCEPT_THRESHOLD = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_STEP_LIMIT = 1'b1;

  localparam logic [ThreshW-1:0] THRESH_RESET = 31'd1;
  localparam logic [LimitW-1:0] LIMIT_RESET = 16'd10;

  localparam logic op_restart = 1'b1;

  localparam logic signed [RatioW-1:0] RATIO_ONE = 32'sh0001_0000;
  localparam logic signed [RatioW-1:0] RATIO_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [RatioW-1:0] RATIO_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                     op;
    logic signed [MeritW-1:0] iterate_merit_in;
    logic signed [MeritW-1:0] trial_exact_in;
    logic signed [MeritW-1:0] trial_model_in;
  } in_item_t;

  typedef struct packed {
    logic                     accepted;
    logic signed [RatioW-1:0] ratio_out;
    logic                     ratio_saturated;
  } out_item_t;

  typedef struct packed {
    logic                     start;
    logic signed [MeritW-1:0] num;
    logic signed [MeritW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [RatioW-1:0] quo;
    logic                     sat;
  } div_rsp_t;

endpackage

### design/nsa_divider.sv
// radix-2 restoring divider giving a saturated signed Q16.16 ratio num/den
// depends on nsa_pkg for the request and response structs
module nsa_divider (
  input  logic              clk,
  input  logic              rst,
  input  nsa_pkg::div_req_t req,
  output nsa_pkg::div_rsp_t rsp
);
  import nsa_pkg::*;

  typedef enum logic [4:0] {
    D_IDLE  = 5'b00001,
    D_CHECK = 5'b00010,
    D_ITER  = 5'b00100,
    D_FIN   = 5'b01000,
    D_DONE  = 5'b10000
  } dstate_t;

  dstate_t state;
  logic neg;
  logic [MeritW-1:0] n_mag;
  logic [MeritW-1:0] d_mag;
  logic [MeritW-1:0] rem;
  logic [RatioW-1:0] shin;
  logic [RatioW-1:0] q;
  logic [4:0] cnt;
  logic signed [RatioW-1:0] quo;
  logic sat;

  logic [MeritW:0] trial;
  logic overflow;
  logic over_limit;
  logic [RatioW-1:0] clamped;

  function automatic logic [MeritW-1:0] mag(input logic signed [MeritW-1:0] x);
    mag = x[MeritW-1] ? (~x + 64'd1) : x;
  endfunction

  assign trial = {rem, shin[RatioW-1]};
  // quotient reaches 2^16 exactly when the top 48 bits of n are not below d
  assign overflow = (d_mag == '0) || ({16'b0, n_mag[MeritW-1:16]} >= d_mag);
  assign over_limit = neg ? (q > 32'h8000_0000) : q[RatioW-1];
  assign clamped = over_limit ? (neg ? 32'h8000_0000 : 32'h7FFF_FFFF) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            neg <= req.num[MeritW-1] ^ req.den[MeritW-1];
            n_mag <= mag(req.num);
            d_mag <= mag(req.den);
            state <= D_CHECK;
          end
        end
        D_CHECK: begin
          if (overflow) begin
            sat <= 1'b1;
            if (d_mag == '0 && n_mag == '0) begin
              quo <= '0;
            end else begin
              quo <= neg ? RATIO_MIN : RATIO_MAX;
            end
            state <= D_DONE;
          end else begin
            rem <= {16'b0, n_mag[MeritW-1:16]};
            shin <= {n_mag[15:0], 16'b0};
            q <= '0;
            cnt <= '0;
            state <= D_ITER;
          end
        end
        D_ITER: begin
          if (trial >= {1'b0, d_mag}) begin
            rem <= trial[MeritW-1:0] - d_mag;
            q <= {q[RatioW-2:0], 1'b1};
          end else begin
            rem <= trial[MeritW-1:0];
            q <= {q[RatioW-2:0], 1'b0};
          end
          shin <= {shin[RatioW-2:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          sat <= over_limit;
          quo <= neg ? $signed(-clamped) : $signed(clamped);
          state <= D_DONE;
        end
        D_DONE: begin
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign rsp.done = (state == D_DONE);
  assign rsp.quo = quo;
  assign rsp.sat = sat;

endmodule

### design/nonmonotone_step_acceptance.sv
// flow: a restart beat goes from acceptance straight to S_OUT; a trial step runs
// S_RED, S_HIST, S_HGO, S_HWAIT, S_CGO, S_CWAIT, S_DEC, S_UPD, S_OUT, with S_CWAIT
// skipped on equal reductions and S_UPD on a reject; one item at a time, with up
// to two passes through the shared radix-2 divider (one quotient bit per cycle)
// reset: synchronous active-high rst clears the history and handshakes and loads the config defaults
module nonmonotone_step_acceptance (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  nsa_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output nsa_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [nsa_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [nsa_pkg::CfgDataW-1:0]     cfg_data
);
  import nsa_pkg::*;
  `include "nonmonotone_step_acceptance_macros.svh"

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RED   = 10'b0000000010,
    S_HIST  = 10'b0000000100,
    S_HGO   = 10'b0000001000,
    S_HWAIT = 10'b0000010000,
    S_CGO   = 10'b0000100000,
    S_CWAIT = 10'b0001000000,
    S_DEC   = 10'b0010000000,
    S_UPD   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;

  logic [ThreshW-1:0] accept_threshold;
  logic [LimitW-1:0] step_limit;

  logic started;
  logic signed [MeritW-1:0] min_merit;
  logic signed [MeritW-1:0] ref_merit;
  logic signed [MeritW-1:0] max_merit;
  logic signed [MeritW-1:0] decrease_sum_ref;
  logic signed [MeritW-1:0] decrease_sum_max;
  logic [LimitW-1:0] steps_since_min;

  logic signed [MeritW-1:0] it_m;
  logic signed [MeritW-1:0] tex_m;
  logic signed [MeritW-1:0] tmo_m;
  logic signed [MeritW-1:0] exact_red;
  logic signed [MeritW-1:0] model_red;
  logic signed [MeritW-1:0] hist_num;
  logic signed [MeritW-1:0] hist_den;
  logic signed [RatioW-1:0] hist_ratio;
  logic signed [RatioW-1:0] cur_ratio;
  logic signed [RatioW-1:0] best;
  logic acc;
  logic sat;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [RatioW-1:0] best_next;
  logic acc_next;
  logic lower;
  logic signed [MeritW-1:0] max_1;
  logic signed [MeritW-1:0] dsr_1;
  logic signed [MeritW-1:0] dsm_1;
  logic [LimitW-1:0] cnt_1;
  logic raise;
  logic signed [MeritW-1:0] max_2;
  logic signed [MeritW-1:0] dsm_2;
  logic out_free;
  logic out_ratio_meets;

  function automatic logic signed [MeritW-1:0] sat_add(
    input logic signed [MeritW-1:0] a,
    input logic signed [MeritW-1:0] b
  );
    logic signed [MeritW-1:0] s;
    s = a + b;
    if (a[MeritW-1] == b[MeritW-1] && s[MeritW-1] != a[MeritW-1]) begin
      sat_add = a[MeritW-1] ? {1'b1, {(MeritW-1){1'b0}}} : {1'b0, {(MeritW-1){1'b1}}};
    end else begin
      sat_add = s;
    end
  endfunction

  function automatic logic signed [MeritW-1:0] sat_sub(
    input logic signed [MeritW-1:0] a,
    input logic signed [MeritW-1:0] b
  );
    logic signed [MeritW-1:0] s;
    s = a - b;
    if (a[MeritW-1] != b[MeritW-1] && s[MeritW-1] != a[MeritW-1]) begin
      sat_sub = a[MeritW-1] ? {1'b1, {(MeritW-1){1'b0}}} : {1'b0, {(MeritW-1){1'b1}}};
    end else begin
      sat_sub = s;
    end
  endfunction

  nsa_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    div_req.start = (state == S_HGO) || (state == S_CGO && exact_red != model_red);
    div_req.num = (state == S_HGO) ? hist_num : exact_red;
    div_req.den = (state == S_HGO) ? hist_den : model_red;
  end

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // decision on the larger ratio against the unsigned threshold
  assign best_next = (cur_ratio > hist_ratio) ? cur_ratio : hist_ratio;
  assign acc_next = $signed({best_next[RatioW-1], best_next}) >=
                    $signed({2'b00, accept_threshold});

  // history update after an accepted step, in model order
  always_comb begin
    lower = it_m < min_merit;
    max_1 = lower ? it_m : max_merit;
    dsr_1 = lower ? '0 : decrease_sum_ref;
    dsm_1 = lower ? '0 : decrease_sum_max;
    cnt_1 = lower ? '0 : steps_since_min + 16'd1;
    raise = it_m > max_1;
    max_2 = raise ? it_m : max_1;
    dsm_2 = raise ? '0 : dsm_1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accept_threshold <= THRESH_RESET;
      step_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACCEPT_THRESHOLD: accept_threshold <= cfg_data[ThreshW-1:0];
        REG_STEP_LIMIT:       step_limit <= cfg_data[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      started <= 1'b0;
      min_merit <= '0;
      ref_merit <= '0;
      max_merit <= '0;
      decrease_sum_ref <= '0;
      decrease_sum_max <= '0;
      steps_since_min <= '0;
    end else begin
      // S_OUT reloads the output register itself when it frees up
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            it_m <= in_data.iterate_merit_in;
            tex_m <= in_data.trial_exact_in;
            tmo_m <= in_data.trial_model_in;
            sat <= 1'b0;
            if (in_data.op == op_restart) begin
              started <= 1'b0;
              acc <= 1'b0;
              best <= '0;
              state <= S_OUT;
            end else begin
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          exact_red <= sat_sub(it_m, tex_m);
          model_red <= sat_sub(it_m, tmo_m);
          if (!started) begin
            steps_since_min <= '0;
            min_merit <= it_m;
            ref_merit <= it_m;
            max_merit <= it_m;
            decrease_sum_ref <= '0;
            decrease_sum_max <= '0;
            started <= 1'b1;
          end
          state <= S_HIST;
        end
        S_HIST: begin
          hist_num <= sat_sub(ref_merit, tex_m);
          hist_den <= sat_add(decrease_sum_ref, model_red);
          state <= S_HGO;
        end
        S_HGO: begin
          state <= S_HWAIT;
        end
        S_HWAIT: begin
          if (div_rsp.done) begin
            hist_ratio <= div_rsp.quo;
            sat <= div_rsp.sat;
            state <= S_CGO;
          end
        end
        S_CGO: begin
          // equal reductions give exactly one with no divide
          if (exact_red == model_red) begin
            cur_ratio <= RATIO_ONE;
            state <= S_DEC;
          end else begin
            state <= S_CWAIT;
          end
        end
        S_CWAIT: begin
          if (div_rsp.done) begin
            cur_ratio <= div_rsp.quo;
            sat <= sat | div_rsp.sat;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          best <= best_next;
          acc <= acc_next;
          if (acc_next) begin
            decrease_sum_ref <= sat_add(decrease_sum_ref, model_red);
            decrease_sum_max <= sat_add(decrease_sum_max, model_red);
            state <= S_UPD;
          end else begin
            state <= S_OUT;
          end
        end
        S_UPD: begin
          min_merit <= lower ? it_m : min_merit;
          max_merit <= max_2;
          decrease_sum_max <= dsm_2;
          steps_since_min <= cnt_1;
          if (cnt_1 == step_limit) begin
            ref_merit <= max_2;
            decrease_sum_ref <= dsm_2;
          end else begin
            decrease_sum_ref <= dsr_1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data.accepted <= acc;
            out_data.ratio_out <= best;
            out_data.ratio_saturated <= sat;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ratio_meets = $signed({out_data.ratio_out[RatioW-1], out_data.ratio_out}) >=
                           $signed({2'b00, accept_threshold});

  `NSA_ASSERT_NOW(a_accept_meets_threshold, out_valid && out_data.accepted, out_ratio_meets, "accepted beat below threshold")
  `NSA_ASSERT_NOW(a_div_done_when_waiting, div_rsp.done, state == S_HWAIT || state == S_CWAIT, "divider result with no one waiting")
  `NSA_ASSERT_NOW(a_started_at_decision, state == S_DEC || state == S_UPD, started, "decision without initialised history")
  `NSA_ASSERT_NEXT(a_out_then_idle, state == S_OUT && out_free, state == S_IDLE && out_valid, "result not handed over")

endmodule
